### rtl/core/c8ie_pkg.sv
// c8ie_pkg: shared types, opcode codes and helper functions for the CHIP-8 core.
// No dependencies; used by every module in rtl/core.
package c8ie_pkg;

    localparam int MEM_BYTES = 4096;
    localparam int SCREEN_W  = 64;
    localparam int SCREEN_H  = 32;
    localparam int MEM_AW    = $clog2(MEM_BYTES);
    localparam int FB_BYTES  = SCREEN_W * SCREEN_H / 8;
    localparam int FB_AW     = $clog2(FB_BYTES);
    localparam int PIXELS    = SCREEN_W * SCREEN_H;

    localparam logic [MEM_AW-1:0] PC_START = MEM_AW'(12'h200);

    localparam logic [1:0] FN_EXEC = 2'd0;
    localparam logic [1:0] FN_WMEM = 2'd1;
    localparam logic [1:0] FN_RPIX = 2'd2;
    localparam logic [1:0] FN_TICK = 2'd3;

    localparam logic [3:0] OP_SYS  = 4'h0;
    localparam logic [3:0] OP_JP   = 4'h1;
    localparam logic [3:0] OP_CALL = 4'h2;
    localparam logic [3:0] OP_SEK  = 4'h3;
    localparam logic [3:0] OP_SNEK = 4'h4;
    localparam logic [3:0] OP_SER  = 4'h5;
    localparam logic [3:0] OP_LDK  = 4'h6;
    localparam logic [3:0] OP_ADDK = 4'h7;
    localparam logic [3:0] OP_ALU  = 4'h8;
    localparam logic [3:0] OP_SNER = 4'h9;
    localparam logic [3:0] OP_LDI  = 4'hA;
    localparam logic [3:0] OP_JPV  = 4'hB;
    localparam logic [3:0] OP_RND  = 4'hC;
    localparam logic [3:0] OP_DRW  = 4'hD;
    localparam logic [3:0] OP_KEY  = 4'hE;
    localparam logic [3:0] OP_MISC = 4'hF;

    localparam logic [15:0] OPC_CLS = 16'h00E0;
    localparam logic [15:0] OPC_RET = 16'h00EE;

    localparam logic [3:0] ALU_MOV = 4'h0;
    localparam logic [3:0] ALU_OR  = 4'h1;
    localparam logic [3:0] ALU_AND = 4'h2;
    localparam logic [3:0] ALU_XOR = 4'h3;
    localparam logic [3:0] ALU_ADD = 4'h4;
    localparam logic [3:0] ALU_SUB = 4'h5;
    localparam logic [3:0] ALU_SHR = 4'h6;
    localparam logic [3:0] ALU_SBN = 4'h7;
    localparam logic [3:0] ALU_SHL = 4'hE;

    localparam logic [7:0] KK_SKP  = 8'h9E;
    localparam logic [7:0] KK_SKNP = 8'hA1;
    localparam logic [7:0] FX_GDT  = 8'h07;
    localparam logic [7:0] FX_WKEY = 8'h0A;
    localparam logic [7:0] FX_SDT  = 8'h15;
    localparam logic [7:0] FX_SST  = 8'h18;
    localparam logic [7:0] FX_ADDI = 8'h1E;
    localparam logic [7:0] FX_FONT = 8'h29;
    localparam logic [7:0] FX_BCD  = 8'h33;
    localparam logic [7:0] FX_STR  = 8'h55;
    localparam logic [7:0] FX_LDR  = 8'h65;

    typedef struct packed {
        logic [1:0]  func;
        logic [11:0] addr;
        logic [7:0]  wdata;
        logic [15:0] keys_down;
        logic [7:0]  rand_byte;
    } t_in;

    typedef struct packed {
        logic [11:0] pc_now;
        logic        read_data;
        logic        waiting_key;
        logic        sound_on;
    } t_out;

    typedef enum logic [4:0] {
        DP_NOP, DP_LOAD_IN, DP_MEMWR, DP_TICK, DP_PX_RD, DP_PX_CAP,
        DP_FETCH_HI, DP_FETCH_LO, DP_CAP_LO, DP_REGRD, DP_EXEC, DP_FLAG,
        DP_CLR, DP_DRW_RD, DP_DRW_A, DP_DRW_AW, DP_DRW_BW, DP_DRW_VF,
        DP_BCD, DP_ST_RD, DP_ST_WR, DP_LD_RD, DP_LD_WR
    } t_dpop;

    typedef struct packed {
        t_dpop      op;
        logic [7:0] cnt;
    } t_cmd;

    typedef struct packed {
        logic [15:0] opcode;
    } t_sts;

    // sel 0: hundreds, 1: tens, 2: ones
    function automatic logic [7:0] bcd_digit(input logic [7:0] v, input logic [1:0] sel);
        logic [1:0]  h;
        logic [6:0]  rem;
        logic [14:0] prod;
        logic [3:0]  t;
        logic [7:0]  res;
        h    = (v >= 8'd200) ? 2'd2 : ((v >= 8'd100) ? 2'd1 : 2'd0);
        rem  = 7'(v - 8'(h) * 8'd100);
        prod = 15'(rem) * 15'd205;
        t    = 4'(prod >> 11);
        case (sel)
            2'd0:    res = 8'(h);
            2'd1:    res = 8'(t);
            default: res = 8'(rem - 7'(t) * 7'd10);
        endcase
        return res;
    endfunction

    function automatic logic [3:0] lowest_key(input logic [15:0] k);
        logic [3:0] r;
        r = 4'd0;
        for (int i = 15; i >= 0; i--) begin
            if (k[i]) r = 4'(i);
        end
        return r;
    endfunction

endpackage

### rtl/core/c8ie_datapath.sv
// c8ie_datapath: architectural state (memory, frame buffer, V registers, I, PC,
// stack, timers) and the operations the controller commands. Uses c8ie_pkg.
module c8ie_datapath #(
    parameter int STACK_DEPTH = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  c8ie_pkg::t_cmd  i_cmd,
    input  c8ie_pkg::t_in   i_in,
    output c8ie_pkg::t_sts  o_sts,
    output c8ie_pkg::t_out  o_res
);

    localparam int SPW = $clog2(STACK_DEPTH);
    localparam int AW  = c8ie_pkg::MEM_AW;
    localparam int FAW = c8ie_pkg::FB_AW;

    logic [7:0] mem [c8ie_pkg::MEM_BYTES];
    logic [7:0] fb  [c8ie_pkg::FB_BYTES];
    logic [7:0] vr  [16];

    logic [15:0]   r_vv;
    logic [7:0]    r_mrd, r_frd, r_va, r_vb, r_spr;
    logic [11:0]   r_addr;
    logic [7:0]    r_wdata, r_rand;
    logic [15:0]   r_keys;
    logic [15:0]   r_op;
    logic [AW-1:0] r_pc, n_pc;
    logic [15:0]   r_i, n_i;
    logic [SPW-1:0] r_sp, n_sp;
    logic [AW-1:0] r_stack [STACK_DEPTH];
    logic [7:0]    r_dt, n_dt, r_st, n_st;
    logic          r_rd, r_wait, n_wait, r_hit, r_flag, n_flag;

    logic [3:0] x, y, nib, sub, cnt4;
    logic [7:0] kk;
    logic [11:0] nnn;
    logic [AW-1:0] pc2, pc4, idx_a, nsel;
    logic [SPW-1:0] sp_inc, sp_dec;
    logic stack_we, key_dn;
    logic [8:0] sum9, ysum;
    logic row_ok, col_ok, b_ok;
    logic [15:0] wide;
    logic [7:0] left, right;
    logic [FAW-1:0] fa_a, fa_b;

    logic mem_we, fb_we, v_we, v_ren;
    logic [AW-1:0] mem_ra, mem_wa;
    logic [7:0] mem_wd, fb_wd, v_wd, ex_vwd;
    logic [FAW-1:0] fb_ra, fb_wa;
    logic [3:0] v_ra, v_wa;
    logic ex_vwe;

    assign x    = r_op[11:8];
    assign y    = r_op[7:4];
    assign nib  = r_op[15:12];
    assign sub  = r_op[3:0];
    assign kk   = r_op[7:0];
    assign nnn  = r_op[11:0];
    assign cnt4 = i_cmd.cnt[3:0];
    assign pc2  = r_pc + AW'(2);
    assign pc4  = r_pc + AW'(4);
    assign idx_a = r_i[AW-1:0] + AW'(cnt4);
    assign sp_inc = (r_sp == SPW'(STACK_DEPTH - 1)) ? '0 : r_sp + SPW'(1);
    assign sp_dec = (r_sp == '0) ? SPW'(STACK_DEPTH - 1) : r_sp - SPW'(1);
    assign key_dn = (r_va[7:4] == 4'd0) && r_keys[r_va[3:0]];
    assign sum9 = {1'b0, r_va} + {1'b0, r_vb};

    assign ysum   = {1'b0, r_vb} + 9'(cnt4);
    assign row_ok = (ysum < 9'(c8ie_pkg::SCREEN_H));
    assign col_ok = (r_va < 8'(c8ie_pkg::SCREEN_W));
    assign b_ok   = row_ok && col_ok && (r_va[5:3] != 3'd7);
    assign wide   = {r_spr, 8'd0} >> r_va[2:0];
    assign left   = wide[15:8];
    assign right  = wide[7:0];
    assign fa_a   = {ysum[4:0], r_va[5:3]};
    assign fa_b   = {ysum[4:0], r_va[5:3] + 3'd1};

    assign o_sts.opcode = r_op;
    assign o_res.pc_now      = r_pc;
    assign o_res.read_data   = r_rd;
    assign o_res.waiting_key = r_wait;
    assign o_res.sound_on    = (r_st != 8'd0);

    always_comb begin
        n_pc = r_pc; n_i = r_i; n_sp = r_sp; n_dt = r_dt; n_st = r_st;
        n_wait = r_wait; n_flag = r_flag; stack_we = 1'b0;
        ex_vwe = 1'b0; ex_vwd = 8'd0; nsel = pc2;
        if (i_cmd.op == c8ie_pkg::DP_LOAD_IN) n_wait = 1'b0;
        if (i_cmd.op == c8ie_pkg::DP_TICK) begin
            if (r_dt != 8'd0) n_dt = r_dt - 8'd1;
            if (r_st != 8'd0) n_st = r_st - 8'd1;
        end
        if (i_cmd.op == c8ie_pkg::DP_EXEC) begin
            case (nib)
                c8ie_pkg::OP_SYS: begin
                    if (r_op == c8ie_pkg::OPC_RET) begin
                        n_sp = sp_dec;
                        nsel = r_stack[sp_dec];
                    end
                end
                c8ie_pkg::OP_JP:   nsel = nnn;
                c8ie_pkg::OP_CALL: begin
                    stack_we = 1'b1;
                    n_sp = sp_inc;
                    nsel = nnn;
                end
                c8ie_pkg::OP_SEK:  if (r_va == kk) nsel = pc4;
                c8ie_pkg::OP_SNEK: if (r_va != kk) nsel = pc4;
                c8ie_pkg::OP_SER:  if (r_va == r_vb) nsel = pc4;
                c8ie_pkg::OP_SNER: if (r_va != r_vb) nsel = pc4;
                c8ie_pkg::OP_LDK:  begin ex_vwe = 1'b1; ex_vwd = kk; end
                c8ie_pkg::OP_ADDK: begin ex_vwe = 1'b1; ex_vwd = r_va + kk; end
                c8ie_pkg::OP_RND:  begin ex_vwe = 1'b1; ex_vwd = r_rand & kk; end
                c8ie_pkg::OP_LDI:  n_i = {4'd0, nnn};
                c8ie_pkg::OP_JPV:  nsel = {4'd0, r_va} + nnn;
                c8ie_pkg::OP_ALU: begin
                    ex_vwe = 1'b1;
                    case (sub)
                        c8ie_pkg::ALU_MOV: ex_vwd = r_vb;
                        c8ie_pkg::ALU_OR:  ex_vwd = r_va | r_vb;
                        c8ie_pkg::ALU_AND: ex_vwd = r_va & r_vb;
                        c8ie_pkg::ALU_XOR: ex_vwd = r_va ^ r_vb;
                        c8ie_pkg::ALU_ADD: begin ex_vwd = sum9[7:0]; n_flag = sum9[8]; end
                        c8ie_pkg::ALU_SUB: begin
                            ex_vwd = r_va - r_vb; n_flag = (r_va > r_vb);
                        end
                        c8ie_pkg::ALU_SHR: begin ex_vwd = r_va >> 1; n_flag = r_va[0]; end
                        c8ie_pkg::ALU_SBN: begin
                            ex_vwd = r_vb - r_va; n_flag = (r_vb > r_va);
                        end
                        c8ie_pkg::ALU_SHL: begin ex_vwd = r_va << 1; n_flag = r_va[7]; end
                        default: ex_vwe = 1'b0;
                    endcase
                end
                c8ie_pkg::OP_KEY: begin
                    if ((kk == c8ie_pkg::KK_SKP && key_dn) ||
                        (kk == c8ie_pkg::KK_SKNP && !key_dn)) nsel = pc4;
                end
                c8ie_pkg::OP_MISC: begin
                    case (kk)
                        c8ie_pkg::FX_GDT: begin ex_vwe = 1'b1; ex_vwd = r_dt; end
                        c8ie_pkg::FX_WKEY: begin
                            if (r_keys == 16'd0) begin
                                nsel = r_pc; n_wait = 1'b1;
                            end else begin
                                ex_vwe = 1'b1;
                                ex_vwd = {4'd0, c8ie_pkg::lowest_key(r_keys)};
                            end
                        end
                        c8ie_pkg::FX_SDT:  n_dt = r_va;
                        c8ie_pkg::FX_SST:  n_st = r_va;
                        c8ie_pkg::FX_ADDI: n_i = r_i + {8'd0, r_va};
                        c8ie_pkg::FX_FONT: n_i = {6'd0, r_va, 2'd0} + {8'd0, r_va};
                        default: ;
                    endcase
                end
                default: ;
            endcase
            n_pc = nsel;
        end
    end

    always_comb begin
        mem_we = 1'b0; mem_wa = r_addr; mem_wd = r_wdata; mem_ra = r_pc;
        case (i_cmd.op)
            c8ie_pkg::DP_MEMWR: mem_we = 1'b1;
            c8ie_pkg::DP_BCD: begin
                mem_we = 1'b1; mem_wa = idx_a;
                mem_wd = c8ie_pkg::bcd_digit(r_va, i_cmd.cnt[1:0]);
            end
            c8ie_pkg::DP_ST_WR: begin mem_we = 1'b1; mem_wa = idx_a; mem_wd = r_va; end
            c8ie_pkg::DP_FETCH_LO: mem_ra = r_pc + AW'(1);
            c8ie_pkg::DP_DRW_RD, c8ie_pkg::DP_LD_RD: mem_ra = idx_a;
            default: ;
        endcase
    end

    always_comb begin
        fb_we = 1'b0; fb_wa = fa_a; fb_wd = 8'd0; fb_ra = r_addr[FAW+2:3];
        case (i_cmd.op)
            c8ie_pkg::DP_CLR: begin fb_we = 1'b1; fb_wa = i_cmd.cnt[FAW-1:0]; end
            c8ie_pkg::DP_DRW_A: fb_ra = fa_a;
            c8ie_pkg::DP_DRW_AW: begin
                fb_ra = fa_b; fb_we = row_ok && col_ok; fb_wd = r_frd ^ left;
            end
            c8ie_pkg::DP_DRW_BW: begin
                fb_we = b_ok; fb_wa = fa_b; fb_wd = r_frd ^ right;
            end
            default: ;
        endcase
    end

    always_comb begin
        v_we = 1'b0; v_wa = x; v_wd = ex_vwd;
        v_ren = 1'b0; v_ra = x;
        case (i_cmd.op)
            c8ie_pkg::DP_EXEC:   v_we = ex_vwe;
            c8ie_pkg::DP_FLAG:   begin v_we = 1'b1; v_wa = 4'hF; v_wd = {7'd0, r_flag}; end
            c8ie_pkg::DP_DRW_VF: begin v_we = 1'b1; v_wa = 4'hF; v_wd = {7'd0, r_hit}; end
            c8ie_pkg::DP_LD_WR:  begin v_we = 1'b1; v_wa = cnt4; v_wd = r_mrd; end
            c8ie_pkg::DP_REGRD: begin
                v_ren = 1'b1;
                if (nib == c8ie_pkg::OP_JPV) v_ra = 4'd0;
            end
            c8ie_pkg::DP_ST_RD:  begin v_ren = 1'b1; v_ra = cnt4; end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_wa] <= mem_wd;
        r_mrd <= mem[mem_ra];
        if (fb_we) fb[fb_wa] <= fb_wd;
        r_frd <= fb[fb_ra];
        if (v_we) vr[v_wa] <= v_wd;
        if (v_ren) r_va <= r_vv[v_ra] ? vr[v_ra] : 8'd0;
        if (i_cmd.op == c8ie_pkg::DP_REGRD) r_vb <= r_vv[y] ? vr[y] : 8'd0;
        if (i_cmd.op == c8ie_pkg::DP_LOAD_IN) begin
            r_addr <= i_in.addr; r_wdata <= i_in.wdata;
            r_keys <= i_in.keys_down; r_rand <= i_in.rand_byte;
        end
        if (i_cmd.op == c8ie_pkg::DP_FETCH_LO) r_op[15:8] <= r_mrd;
        if (i_cmd.op == c8ie_pkg::DP_CAP_LO)   r_op[7:0]  <= r_mrd;
        if (i_cmd.op == c8ie_pkg::DP_DRW_A)    r_spr <= r_mrd;
        r_flag <= n_flag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vv <= '0; r_pc <= c8ie_pkg::PC_START; r_i <= '0; r_sp <= '0;
            r_dt <= '0; r_st <= '0; r_rd <= 1'b0; r_wait <= 1'b0; r_hit <= 1'b0;
            for (int k = 0; k < STACK_DEPTH; k++) r_stack[k] <= '0;
        end else begin
            if (v_we) r_vv[v_wa] <= 1'b1;
            r_pc <= n_pc; r_i <= n_i; r_sp <= n_sp; r_dt <= n_dt; r_st <= n_st;
            r_wait <= n_wait;
            if (stack_we) r_stack[r_sp] <= pc2;
            case (i_cmd.op)
                c8ie_pkg::DP_LOAD_IN: r_rd <= 1'b0;
                c8ie_pkg::DP_PX_CAP:
                    r_rd <= !r_addr[11] && r_frd[3'd7 - r_addr[2:0]];
                c8ie_pkg::DP_REGRD: r_hit <= 1'b0;
                c8ie_pkg::DP_DRW_AW:
                    if (row_ok && col_ok && ((r_frd & left) != 8'd0)) r_hit <= 1'b1;
                c8ie_pkg::DP_DRW_BW:
                    if (b_ok && ((r_frd & right) != 8'd0)) r_hit <= 1'b1;
                default: ;
            endcase
        end
    end

endmodule

### rtl/core/c8ie_ctrl.sv
// c8ie_ctrl: sequencer for the CHIP-8 core; walks fetch, decode and the
// multi-cycle loops and commands c8ie_datapath. Uses c8ie_pkg.
module c8ie_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  logic [1:0]     i_func,
    input  logic           i_out_free,
    input  c8ie_pkg::t_sts i_sts,
    output c8ie_pkg::t_cmd o_cmd,
    output logic           o_busy,
    output logic           o_done
);

    typedef enum logic [4:0] {
        S_BOOT, S_IDLE, S_WR, S_TICK, S_PX0, S_PX1, S_F0, S_F1, S_F2, S_RR,
        S_CLR, S_D0, S_D1, S_D2, S_D3, S_DVF, S_BCD, S_ST0, S_ST1, S_LD0, S_LD1,
        S_EX, S_FL, S_DONE
    } t_state;

    t_state     r_state;
    logic [7:0] r_cnt;
    logic [15:0] opc;
    logic [3:0] nib, nrows, rx;
    logic [7:0] kk;
    logic       flag_op;

    assign opc   = i_sts.opcode;
    assign nib   = opc[15:12];
    assign rx    = opc[11:8];
    assign nrows = opc[3:0];
    assign kk    = opc[7:0];

    always_comb begin
        flag_op = 1'b0;
        if (nib == c8ie_pkg::OP_ALU) begin
            case (opc[3:0]) inside
                c8ie_pkg::ALU_ADD, c8ie_pkg::ALU_SUB, c8ie_pkg::ALU_SHR,
                c8ie_pkg::ALU_SBN, c8ie_pkg::ALU_SHL: flag_op = 1'b1;
                default: flag_op = 1'b0;
            endcase
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = (r_state == S_DONE) && i_out_free;

    always_comb begin
        o_cmd.cnt = r_cnt;
        unique case (r_state)
            S_BOOT, S_CLR: o_cmd.op = c8ie_pkg::DP_CLR;
            S_IDLE:  o_cmd.op = i_accept ? c8ie_pkg::DP_LOAD_IN : c8ie_pkg::DP_NOP;
            S_WR:    o_cmd.op = c8ie_pkg::DP_MEMWR;
            S_TICK:  o_cmd.op = c8ie_pkg::DP_TICK;
            S_PX0:   o_cmd.op = c8ie_pkg::DP_PX_RD;
            S_PX1:   o_cmd.op = c8ie_pkg::DP_PX_CAP;
            S_F0:    o_cmd.op = c8ie_pkg::DP_FETCH_HI;
            S_F1:    o_cmd.op = c8ie_pkg::DP_FETCH_LO;
            S_F2:    o_cmd.op = c8ie_pkg::DP_CAP_LO;
            S_RR:    o_cmd.op = c8ie_pkg::DP_REGRD;
            S_D0:    o_cmd.op = c8ie_pkg::DP_DRW_RD;
            S_D1:    o_cmd.op = c8ie_pkg::DP_DRW_A;
            S_D2:    o_cmd.op = c8ie_pkg::DP_DRW_AW;
            S_D3:    o_cmd.op = c8ie_pkg::DP_DRW_BW;
            S_DVF:   o_cmd.op = c8ie_pkg::DP_DRW_VF;
            S_BCD:   o_cmd.op = c8ie_pkg::DP_BCD;
            S_ST0:   o_cmd.op = c8ie_pkg::DP_ST_RD;
            S_ST1:   o_cmd.op = c8ie_pkg::DP_ST_WR;
            S_LD0:   o_cmd.op = c8ie_pkg::DP_LD_RD;
            S_LD1:   o_cmd.op = c8ie_pkg::DP_LD_WR;
            S_EX:    o_cmd.op = c8ie_pkg::DP_EXEC;
            S_FL:    o_cmd.op = c8ie_pkg::DP_FLAG;
            S_DONE:  o_cmd.op = c8ie_pkg::DP_NOP;
            default: o_cmd.op = c8ie_pkg::DP_NOP;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_BOOT;
            r_cnt   <= '0;
        end else begin
            unique case (r_state)
                S_BOOT: begin
                    r_cnt <= r_cnt + 8'd1;
                    if (r_cnt == 8'(c8ie_pkg::FB_BYTES - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    r_cnt <= '0;
                    if (i_accept) begin
                        unique case (i_func)
                            c8ie_pkg::FN_EXEC: r_state <= S_F0;
                            c8ie_pkg::FN_WMEM: r_state <= S_WR;
                            c8ie_pkg::FN_RPIX: r_state <= S_PX0;
                            default:           r_state <= S_TICK;
                        endcase
                    end
                end
                S_WR, S_TICK, S_PX1: r_state <= S_DONE;
                S_PX0: r_state <= S_PX1;
                S_F0:  r_state <= S_F1;
                S_F1:  r_state <= S_F2;
                S_F2:  r_state <= S_RR;
                S_RR: begin
                    r_cnt <= '0;
                    if (opc == c8ie_pkg::OPC_CLS) r_state <= S_CLR;
                    else if (nib == c8ie_pkg::OP_DRW)
                        r_state <= (nrows == 4'd0) ? S_DVF : S_D0;
                    else if (nib == c8ie_pkg::OP_MISC && kk == c8ie_pkg::FX_BCD)
                        r_state <= S_BCD;
                    else if (nib == c8ie_pkg::OP_MISC && kk == c8ie_pkg::FX_STR)
                        r_state <= S_ST0;
                    else if (nib == c8ie_pkg::OP_MISC && kk == c8ie_pkg::FX_LDR)
                        r_state <= S_LD0;
                    else r_state <= S_EX;
                end
                S_CLR: begin
                    r_cnt <= r_cnt + 8'd1;
                    if (r_cnt == 8'(c8ie_pkg::FB_BYTES - 1)) r_state <= S_EX;
                end
                S_D0: r_state <= S_D1;
                S_D1: r_state <= S_D2;
                S_D2: r_state <= S_D3;
                S_D3: begin
                    r_cnt <= r_cnt + 8'd1;
                    r_state <= (r_cnt[3:0] == nrows - 4'd1) ? S_DVF : S_D0;
                end
                S_DVF: r_state <= S_EX;
                S_BCD: begin
                    r_cnt <= r_cnt + 8'd1;
                    if (r_cnt == 8'd2) r_state <= S_EX;
                end
                S_ST0: r_state <= S_ST1;
                S_ST1: begin
                    r_cnt <= r_cnt + 8'd1;
                    r_state <= (r_cnt[3:0] == rx) ? S_EX : S_ST0;
                end
                S_LD0: r_state <= S_LD1;
                S_LD1: begin
                    r_cnt <= r_cnt + 8'd1;
                    r_state <= (r_cnt[3:0] == rx) ? S_EX : S_LD0;
                end
                S_EX: r_state <= flag_op ? S_FL : S_DONE;
                S_FL: r_state <= S_DONE;
                S_DONE: if (i_out_free) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept |=> o_busy) else $error("accept did not start work");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_busy) else $error("done without return to idle");
    a_draw_rows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_D0) |-> (r_cnt < 8'd16)) else $error("draw row overrun");
    a_loop_regs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ST0 || r_state == S_LD0) |-> (r_cnt[7:4] == 4'd0))
        else $error("register block move overrun");

endmodule

### rtl/core/chip8_instruction_executor.sv
// chip8_instruction_executor: top level of the CHIP-8 core; joins c8ie_ctrl and
// c8ie_datapath and holds the result register. Uses c8ie_pkg.
//
// Input channel i_in (valid/stall): func 0 runs one instruction, 1 writes a
// memory byte, 2 reads a pixel, 3 ticks both timers. Output channel o_out
// carries one result transaction per input transaction, in order.
// Dxyn loops over its n sprite rows, Fx55/Fx65 over registers V0..Vx, Fx33 over
// its three digits, and 00E0 clears one frame buffer byte per cycle. Work is
// bounded by the single read port of the program memory and the frame buffer.
// One transaction is worked at a time; a new one is taken once the previous
// result sits in the output register, so a stalled receiver holds the block
// only when a second result is ready.
// After reset the frame buffer is swept clear with o_in_stall high; PC starts at
// 0x200, all other state zero, program memory undefined until loaded with func 1.
module chip8_instruction_executor #(
    parameter int STACK_DEPTH = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  c8ie_pkg::t_in  i_in,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output c8ie_pkg::t_out o_out
);

    c8ie_pkg::t_cmd cmd;
    c8ie_pkg::t_sts sts;
    c8ie_pkg::t_out res;
    logic busy, done, accept, out_free;
    logic r_out_valid;
    c8ie_pkg::t_out r_out;

    assign o_in_stall  = busy;
    assign accept      = i_in_valid && !busy;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    c8ie_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_func     (i_in.func),
        .i_out_free (out_free),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_busy     (busy),
        .o_done     (done)
    );

    c8ie_datapath #(.STACK_DEPTH(STACK_DEPTH)) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_in    (i_in),
        .o_sts   (sts),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (done) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) r_out <= res;
    end

endmodule

### sim/chip8_instruction_executor_tb.sv
// Testbench for chip8_instruction_executor: drives transactions on i_in and
// checks o_out against an in-bench CHIP-8 predictor. Depends on c8ie_pkg and the RTL.
module chip8_instruction_executor_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_ITEMS    = 2000;
    localparam int IDLE_LIMIT = 6000;

    class exec_scoreboard;
        bit [7:0]  mem [c8ie_pkg::MEM_BYTES];
        bit        written [c8ie_pkg::MEM_BYTES];
        bit        pix [c8ie_pkg::PIXELS];
        bit [7:0]  vr [16];
        bit [15:0] ir;
        bit [11:0] pc;
        bit [3:0]  sp;
        bit [11:0] stk [16];
        bit [7:0]  dly;
        bit [7:0]  snd;
        c8ie_pkg::t_out exp_results [$];
        int        errors;

        function new();
            pc = c8ie_pkg::PC_START;
        endfunction

        // Runs the opcode at pc; returns 1 when a key wait found no key down.
        function bit run_instruction(bit [15:0] keys, bit [7:0] rnd);
            bit [15:0] op;
            bit [3:0]  x, y, n;
            bit [7:0]  kk, vx, vy, bits;
            bit [11:0] nnn, npc;
            bit [8:0]  sum;
            bit        hit, down;
            int        col, row;
            op  = {mem[pc], mem[pc + 12'd1]};
            x   = op[11:8];
            y   = op[7:4];
            n   = op[3:0];
            kk  = op[7:0];
            nnn = op[11:0];
            vx  = vr[x];
            vy  = vr[y];
            npc = pc + 12'd2;
            case (op[15:12])
                c8ie_pkg::OP_SYS: begin
                    if (op == c8ie_pkg::OPC_CLS) begin
                        foreach (pix[i]) pix[i] = 1'b0;
                    end else if (op == c8ie_pkg::OPC_RET) begin
                        sp  = sp - 4'd1;
                        npc = stk[sp];
                    end
                end
                c8ie_pkg::OP_JP:   npc = nnn;
                c8ie_pkg::OP_CALL: begin
                    stk[sp] = npc;
                    sp      = sp + 4'd1;
                    npc     = nnn;
                end
                c8ie_pkg::OP_SEK:  if (vx == kk) npc += 12'd2;
                c8ie_pkg::OP_SNEK: if (vx != kk) npc += 12'd2;
                c8ie_pkg::OP_SER:  if (vx == vy) npc += 12'd2;
                c8ie_pkg::OP_LDK:  vr[x] = kk;
                c8ie_pkg::OP_ADDK: vr[x] = vx + kk;
                c8ie_pkg::OP_ALU: begin
                    case (n)
                        c8ie_pkg::ALU_MOV: vr[x] = vy;
                        c8ie_pkg::ALU_OR:  vr[x] = vx | vy;
                        c8ie_pkg::ALU_AND: vr[x] = vx & vy;
                        c8ie_pkg::ALU_XOR: vr[x] = vx ^ vy;
                        c8ie_pkg::ALU_ADD: begin
                            sum    = {1'b0, vx} + {1'b0, vy};
                            vr[x]  = sum[7:0];
                            vr[15] = {7'd0, sum[8]};
                        end
                        c8ie_pkg::ALU_SUB: begin
                            vr[x]  = vx - vy;
                            vr[15] = {7'd0, vx > vy};
                        end
                        c8ie_pkg::ALU_SHR: begin
                            vr[x]  = vx >> 1;
                            vr[15] = {7'd0, vx[0]};
                        end
                        c8ie_pkg::ALU_SBN: begin
                            vr[x]  = vy - vx;
                            vr[15] = {7'd0, vy > vx};
                        end
                        c8ie_pkg::ALU_SHL: begin
                            vr[x]  = vx << 1;
                            vr[15] = {7'd0, vx[7]};
                        end
                        default: ;
                    endcase
                end
                c8ie_pkg::OP_SNER: if (vx != vy) npc += 12'd2;
                c8ie_pkg::OP_LDI:  ir = {4'd0, nnn};
                c8ie_pkg::OP_JPV:  npc = nnn + {4'd0, vr[0]};
                c8ie_pkg::OP_RND:  vr[x] = rnd & kk;
                c8ie_pkg::OP_DRW: begin
                    hit = 1'b0;
                    for (int r = 0; r < n; r++) begin
                        bits = mem[ir[11:0] + 12'(r)];
                        for (int c = 0; c < 8; c++) begin
                            col = int'(vx) + c;
                            row = int'(vy) + r;
                            if (bits[7-c] && col < c8ie_pkg::SCREEN_W &&
                                row < c8ie_pkg::SCREEN_H) begin
                                pix[row*c8ie_pkg::SCREEN_W+col] ^= 1'b1;
                                if (!pix[row*c8ie_pkg::SCREEN_W+col]) hit = 1'b1;
                            end
                        end
                    end
                    vr[15] = {7'd0, hit};
                end
                c8ie_pkg::OP_KEY: begin
                    down = (vx < 8'd16) && keys[vx[3:0]];
                    if (kk == c8ie_pkg::KK_SKP && down) npc += 12'd2;
                    else if (kk == c8ie_pkg::KK_SKNP && !down) npc += 12'd2;
                end
                c8ie_pkg::OP_MISC: begin
                    case (kk)
                        c8ie_pkg::FX_GDT:  vr[x] = dly;
                        c8ie_pkg::FX_WKEY: begin
                            if (keys == 16'd0) return 1'b1;
                            for (int i = 15; i >= 0; i--) if (keys[i]) vr[x] = 8'(i);
                        end
                        c8ie_pkg::FX_SDT:  dly = vx;
                        c8ie_pkg::FX_SST:  snd = vx;
                        c8ie_pkg::FX_ADDI: ir = ir + {8'd0, vx};
                        c8ie_pkg::FX_FONT: ir = {8'd0, vx} * 16'd5;
                        c8ie_pkg::FX_BCD: begin
                            mem[ir[11:0]]         = vx / 8'd100;
                            mem[ir[11:0] + 12'd1] = (vx / 8'd10) % 8'd10;
                            mem[ir[11:0] + 12'd2] = vx % 8'd10;
                            for (int i = 0; i < 3; i++) written[ir[11:0] + 12'(i)] = 1'b1;
                        end
                        c8ie_pkg::FX_STR: begin
                            for (int i = 0; i <= x; i++) begin
                                mem[ir[11:0] + 12'(i)]     = vr[i];
                                written[ir[11:0] + 12'(i)] = 1'b1;
                            end
                        end
                        c8ie_pkg::FX_LDR:
                            for (int i = 0; i <= x; i++) vr[i] = mem[ir[11:0] + 12'(i)];
                        default: ;
                    endcase
                end
                default: ;
            endcase
            pc = npc;
            return 1'b0;
        endfunction

        function void note_input(c8ie_pkg::t_in it);
            c8ie_pkg::t_out e;
            e = '0;
            case (it.func)
                c8ie_pkg::FN_EXEC:
                    e.waiting_key = run_instruction(it.keys_down, it.rand_byte);
                c8ie_pkg::FN_WMEM: begin
                    mem[it.addr]     = it.wdata;
                    written[it.addr] = 1'b1;
                end
                c8ie_pkg::FN_RPIX:
                    e.read_data = (it.addr < c8ie_pkg::PIXELS) ? pix[it.addr] : 1'b0;
                default: begin
                    if (dly != 0) dly--;
                    if (snd != 0) snd--;
                end
            endcase
            e.pc_now   = pc;
            e.sound_on = (snd != 0);
            exp_results.push_back(e);
        endfunction

        function void check_result(c8ie_pkg::t_out got);
            c8ie_pkg::t_out e;
            if (exp_results.size() == 0) begin
                $error("result with nothing expected: %h", got);
                errors++;
                return;
            end
            e = exp_results.pop_front();
            if (got.pc_now !== e.pc_now) begin
                $error("pc_now exp %h got %h", e.pc_now, got.pc_now);
                errors++;
            end
            if (got.read_data !== e.read_data) begin
                $error("read_data exp %b got %b", e.read_data, got.read_data);
                errors++;
            end
            if (got.waiting_key !== e.waiting_key) begin
                $error("waiting_key exp %b got %b", e.waiting_key, got.waiting_key);
                errors++;
            end
            if (got.sound_on !== e.sound_on) begin
                $error("sound_on exp %b got %b", e.sound_on, got.sound_on);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    c8ie_pkg::t_in  i_in = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    c8ie_pkg::t_out o_out;

    exec_scoreboard sb = new();
    int in_idle_pct = 0;
    int out_stall_pct = 0;
    int idle_cycles = 0;
    int n_sent = 0;

    chip8_instruction_executor i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in       (i_in),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out      (o_out)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) sb.check_result(o_out);
            i_out_stall <= ($urandom_range(99) < out_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    task automatic send_item(c8ie_pkg::t_in it);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= it;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_input(it);
        n_sent++;
    endtask

    function automatic c8ie_pkg::t_in make_item(logic [1:0] func, logic [11:0] addr,
                                                logic [7:0] wdata, logic [15:0] keys);
        c8ie_pkg::t_in it;
        it.func      = func;
        it.addr      = addr;
        it.wdata     = wdata;
        it.keys_down = keys;
        it.rand_byte = 8'($urandom);
        return it;
    endfunction

    task automatic write_byte(logic [11:0] a, logic [7:0] d);
        send_item(make_item(c8ie_pkg::FN_WMEM, a, d, 16'($urandom)));
    endtask

    task automatic ensure_byte(logic [11:0] a);
        if (!sb.written[a]) write_byte(a, 8'($urandom));
    endtask

    // loads any sprite rows or block-load bytes the next opcode reads
    task automatic prep_operands();
        logic [15:0] op;
        op = {sb.mem[sb.pc], sb.mem[sb.pc + 12'd1]};
        if (op[15:12] == c8ie_pkg::OP_DRW) begin
            for (int r = 0; r < int'(op[3:0]); r++) ensure_byte(sb.ir[11:0] + 12'(r));
        end else if (op[15:12] == c8ie_pkg::OP_MISC && op[7:0] == c8ie_pkg::FX_LDR) begin
            for (int i = 0; i <= int'(op[11:8]); i++) ensure_byte(sb.ir[11:0] + 12'(i));
        end
    endtask

    task automatic run_opcode(logic [15:0] op, logic [15:0] keys);
        write_byte(sb.pc, op[15:8]);
        write_byte(sb.pc + 12'd1, op[7:0]);
        prep_operands();
        send_item(make_item(c8ie_pkg::FN_EXEC, 12'($urandom), 8'($urandom), keys));
    endtask

    function automatic logic [15:0] rand_opcode();
        logic [3:0]  hi, x, y;
        logic [7:0]  kk;
        logic [15:0] op;
        hi = 4'($urandom);
        x  = 4'($urandom);
        y  = 4'($urandom);
        kk = 8'($urandom);
        op = {hi, x, kk};
        case (hi)
            c8ie_pkg::OP_SYS: begin
                case ($urandom_range(7))
                    0:       op = c8ie_pkg::OPC_CLS;
                    1, 2, 3: op = c8ie_pkg::OPC_RET;
                    default: op = {4'h0, 12'($urandom)};
                endcase
            end
            c8ie_pkg::OP_LDK: if ($urandom_range(2) == 0) op = {hi, x, 4'h0, kk[3:0]};
            c8ie_pkg::OP_ALU: begin
                case ($urandom_range(9))
                    0: op = {hi, x, y, c8ie_pkg::ALU_MOV};
                    1: op = {hi, x, y, c8ie_pkg::ALU_OR};
                    2: op = {hi, x, y, c8ie_pkg::ALU_AND};
                    3: op = {hi, x, y, c8ie_pkg::ALU_XOR};
                    4: op = {hi, x, y, c8ie_pkg::ALU_ADD};
                    5: op = {hi, x, y, c8ie_pkg::ALU_SUB};
                    6: op = {hi, x, y, c8ie_pkg::ALU_SHR};
                    7: op = {hi, x, y, c8ie_pkg::ALU_SBN};
                    8: op = {hi, x, y, c8ie_pkg::ALU_SHL};
                    default: op = {hi, x, y, 4'($urandom)};
                endcase
            end
            c8ie_pkg::OP_SER, c8ie_pkg::OP_SNER: op = {hi, x, y, 4'($urandom)};
            c8ie_pkg::OP_KEY: begin
                case ($urandom_range(2))
                    0:       op = {hi, x, c8ie_pkg::KK_SKP};
                    1:       op = {hi, x, c8ie_pkg::KK_SKNP};
                    default: op = {hi, x, kk};
                endcase
            end
            c8ie_pkg::OP_MISC: begin
                case ($urandom_range(11))
                    0:  op = {hi, x, c8ie_pkg::FX_GDT};
                    1:  op = {hi, x, c8ie_pkg::FX_WKEY};
                    2:  op = {hi, x, c8ie_pkg::FX_SDT};
                    3:  op = {hi, x, c8ie_pkg::FX_SST};
                    4:  op = {hi, x, c8ie_pkg::FX_ADDI};
                    5:  op = {hi, x, c8ie_pkg::FX_FONT};
                    6:  op = {hi, x, c8ie_pkg::FX_BCD};
                    7:  op = {hi, x, c8ie_pkg::FX_STR};
                    8:  op = {hi, x, c8ie_pkg::FX_LDR};
                    default: op = {hi, x, kk};
                endcase
            end
            default: ;
        endcase
        return op;
    endfunction

    function automatic logic [15:0] rand_keys();
        case ($urandom_range(3))
            0:       return 16'd0;
            1:       return 16'd1 << $urandom_range(15);
            default: return 16'($urandom);
        endcase
    endfunction

    logic [15:0] dir_ops [25] = '{
        16'h60FF, 16'h6101, 16'h8014, 16'h8015, 16'h8017, 16'h8016, 16'h801E,
        16'h6FC3, 16'h8F1E, 16'h623C, 16'h631E, 16'hA300, 16'hD23F, 16'hD23F,
        16'h6411, 16'hE49E, 16'hE4A1, 16'hF40A, 16'hF40A, 16'hF433, 16'hF455,
        16'h00EE, 16'h60FF, 16'hBFFF, 16'h0123
    };
    logic [15:0] dir_keys [25] = '{
        16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
        16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
        16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h8000, 16'h0000, 16'h0000,
        16'h0000, 16'h0000, 16'h0000, 16'h0000
    };

    initial begin
        int r;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_ops[i]) run_opcode(dir_ops[i], dir_keys[i]);
        run_opcode(16'hF018, 16'd0);
        run_opcode(16'h2FFE, 16'd0);
        run_opcode(16'hFF65, 16'd0);
        run_opcode(c8ie_pkg::OPC_CLS, 16'd0);
        send_item(make_item(c8ie_pkg::FN_TICK, 12'hFFF, 8'hFF, 16'hFFFF));
        send_item(make_item(c8ie_pkg::FN_RPIX, 12'hFFF, 8'h00, 16'h0000));
        send_item(make_item(c8ie_pkg::FN_RPIX, 12'h000, 8'h00, 16'h0000));

        while (n_sent < N_ITEMS) begin
            if (n_sent < N_ITEMS / 3) begin
                in_idle_pct   = 25;
                out_stall_pct = 84;
            end else if (n_sent < 2 * N_ITEMS / 3) begin
                in_idle_pct   = 84;
                out_stall_pct = 25;
            end else begin
                in_idle_pct   = 0;
                out_stall_pct = 0;
            end
            r = $urandom_range(99);
            if (r < 55) begin
                run_opcode(rand_opcode(), rand_keys());
            end else if (r < 65) begin
                write_byte(12'($urandom), 8'($urandom));
            end else if (r < 80) begin
                send_item(make_item(c8ie_pkg::FN_RPIX, ($urandom_range(4) == 0) ?
                                    12'($urandom) : 12'($urandom_range(c8ie_pkg::PIXELS - 1)),
                                    8'($urandom), 16'($urandom)));
            end else if (r < 92) begin
                send_item(make_item(c8ie_pkg::FN_TICK, 12'($urandom), 8'($urandom),
                                    16'($urandom)));
            end else begin
                ensure_byte(sb.pc);
                ensure_byte(sb.pc + 12'd1);
                prep_operands();
                send_item(make_item(c8ie_pkg::FN_EXEC, 12'($urandom), 8'($urandom),
                                    rand_keys()));
            end
        end
        i_in_valid <= 1'b0;

        while (sb.exp_results.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
